[src/ddet_pkg.sv]
// Package for the deadlock detection engine.
// Sizing constants, transaction payload structs, function codes, CSR indexes, sequencer states.
// No dependencies.
package ddet_pkg;

   localparam int MAX_PROCS   = 16;
   localparam int MAX_RES     = 16;
   localparam int COUNT_WIDTH = 16;

   localparam int PIDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int RIDX_W = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
   localparam int ADDR_W = PIDX_W + RIDX_W;
   localparam int PCNT_W = $clog2(MAX_PROCS + 1);
   localparam int RCNT_W = $clog2(MAX_RES + 1);
   localparam int NEED_W = COUNT_WIDTH + 1;
   // available plus every allocation never wraps
   localparam int WORK_W = COUNT_WIDTH + PCNT_W;

   localparam int CFG_W     = 5;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [2:0] {
      FUNC_WR_AVAIL = 3'd0,
      FUNC_WR_ALLOC = 3'd1,
      FUNC_WR_REQ   = 3'd2,
      FUNC_CHECK    = 3'd3,
      FUNC_WHAT_IF  = 3'd4
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_PROCS = 2'd0,
      CSR_NUM_RES   = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [3:0]  proc_index;
      logic [3:0]  res_index;
      logic [15:0] value;
   } ddet_req_type;

   typedef struct packed {
      logic       deadlocked;
      logic [4:0] finished_count;
   } ddet_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT_RD,
      ST_INIT_WR,
      ST_HOLD_RD,
      ST_HOLD_OP,
      ST_PICK,
      ST_FIT_RD,
      ST_FIT_OP,
      ST_ADD_RD,
      ST_ADD_OP,
      ST_DONE
   } state_type;

endpackage

[src/deadlock_detection_engine_core.sv]
// Deadlock detection engine top level: request channel, CSR port, detection sequencer.
// Depends on ddet_pkg and ddet_ram.
//
// Write transactions (available, allocation, request entries) are accepted back to back. A
// check or what-if check runs a sequencer over four RAMs with a registered read port
// (available, allocation, request, work vector); every entry access is a read state followed
// by an operate state, so the sequencer never has a read and a write to the same work entry
// in flight. With np processes a check loads the work vector from the available counts, finds
// the processes holding nothing, then runs reduction passes that scan the unfinished rows
// and add the holdings of every row that fits, at most np+1 passes, then posts the result.
// num_procs = 0 answers at once; num_res = 0 finishes every process at once. No new
// transaction is accepted while a check runs; writes may be taken while a result waits on
// rsp, and a following check waits at its end until the rsp slot is free. CSR writes are
// always accepted and are meant to be issued only while the engine is idle.
module deadlock_detection_engine_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ddet_pkg::ddet_req_type                req,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ddet_pkg::ddet_rsp_type                rsp,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ddet_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ddet_pkg::CFG_W-1:0]            csr_data
);

   import ddet_pkg::*;

   // configuration
   logic [CFG_W-1:0]  num_procs_ff;
   logic [CFG_W-1:0]  num_res_ff;
   logic [PCNT_W-1:0] np_clamped;
   logic [RCNT_W-1:0] nr_clamped;

   // sequencer
   state_type            state_ff, state_in;
   logic [PCNT_W-1:0]    p_ff, p_in;
   logic [RCNT_W-1:0]    r_ff, r_in;
   logic [PCNT_W-1:0]    np_ff, np_in;
   logic [RCNT_W-1:0]    nr_ff, nr_in;
   logic [PCNT_W-1:0]    done_ff, done_in;
   logic [MAX_PROCS-1:0] marks_ff, marks_in;
   logic                 holds_ff, holds_in;
   logic                 fits_ff, fits_in;
   logic                 progress_ff, progress_in;
   logic                 extra_ff, extra_in;
   logic [3:0]           xp_ff, xp_in;
   logic [3:0]           xr_ff, xr_in;
   ddet_rsp_type         rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic req_fire;
   logic r_last;
   logic p_last;
   logic any_held;
   logic fit_now;
   logic extra_hit;
   logic [NEED_W-1:0] need;

   // RAM ports
   logic                   avail_we;
   logic [COUNT_WIDTH-1:0] avail_q;
   logic                   alloc_we;
   logic [COUNT_WIDTH-1:0] alloc_q;
   logic                   reqm_we;
   logic [COUNT_WIDTH-1:0] reqm_q;
   logic                   work_we;
   logic [WORK_W-1:0]      work_wdata;
   logic [WORK_W-1:0]      work_q;
   logic [ADDR_W-1:0]      mat_wr_addr;
   logic [ADDR_W-1:0]      mat_rd_addr;
   logic [COUNT_WIDTH-1:0] wr_value;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Registers above the array size act as the array size.
   assign np_clamped = (32'(num_procs_ff) > MAX_PROCS) ? PCNT_W'(MAX_PROCS)
                                                      : PCNT_W'(num_procs_ff);
   assign nr_clamped = (32'(num_res_ff) > MAX_RES) ? RCNT_W'(MAX_RES)
                                                  : RCNT_W'(num_res_ff);

   // CSR registers
   always_ff @(posedge clock) begin
      if (reset) begin
         num_procs_ff <= CFG_W'(1);
         num_res_ff   <= CFG_W'(1);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_PROCS: num_procs_ff <= csr_data;
            CSR_NUM_RES:   num_res_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Memories: matrix row p, column r lives at {p, r}.
   assign wr_value    = COUNT_WIDTH'(req.value);
   assign mat_wr_addr = {PIDX_W'(req.proc_index), RIDX_W'(req.res_index)};
   assign mat_rd_addr = {p_ff[PIDX_W-1:0], r_ff[RIDX_W-1:0]};

   ddet_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_RES)) u_avail (
      .clock   (clock),
      .wr_en   (avail_we),
      .wr_addr (RIDX_W'(req.res_index)),
      .wr_data (wr_value),
      .rd_addr (r_ff[RIDX_W-1:0]),
      .rd_data (avail_q)
   );

   ddet_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(1 << ADDR_W)) u_alloc (
      .clock   (clock),
      .wr_en   (alloc_we),
      .wr_addr (mat_wr_addr),
      .wr_data (wr_value),
      .rd_addr (mat_rd_addr),
      .rd_data (alloc_q)
   );

   ddet_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(1 << ADDR_W)) u_request (
      .clock   (clock),
      .wr_en   (reqm_we),
      .wr_addr (mat_wr_addr),
      .wr_data (wr_value),
      .rd_addr (mat_rd_addr),
      .rd_data (reqm_q)
   );

   // Work vector: read in *_RD, written in the following *_OP/INIT_WR cycle.
   ddet_ram #(.WIDTH(WORK_W), .DEPTH(MAX_RES)) u_work (
      .clock   (clock),
      .wr_en   (work_we),
      .wr_addr (r_ff[RIDX_W-1:0]),
      .wr_data (work_wdata),
      .rd_addr (r_ff[RIDX_W-1:0]),
      .rd_data (work_q)
   );

   // Datapath terms
   assign r_last    = (r_ff == RCNT_W'(nr_ff - 1'b1));
   assign p_last    = (p_ff == PCNT_W'(np_ff - 1'b1));
   assign any_held  = holds_ff || (alloc_q != '0);
   assign extra_hit = extra_ff && (p_ff == PCNT_W'(xp_ff)) && (r_ff == RCNT_W'(xr_ff));
   // what-if adds one without wrap, hence the extra bit
   assign need      = NEED_W'(reqm_q) + NEED_W'(extra_hit);
   assign fit_now   = (WORK_W'(need) <= work_q);

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      p_in         = p_ff;
      r_in         = r_ff;
      np_in        = np_ff;
      nr_in        = nr_ff;
      done_in      = done_ff;
      marks_in     = marks_ff;
      holds_in     = holds_ff;
      fits_in      = fits_ff;
      progress_in  = progress_ff;
      extra_in     = extra_ff;
      xp_in        = xp_ff;
      xr_in        = xr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      avail_we     = 1'b0;
      alloc_we     = 1'b0;
      reqm_we      = 1'b0;
      work_we      = 1'b0;
      work_wdata   = work_q + WORK_W'(alloc_q);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req.func)
                  FUNC_WR_AVAIL: begin
                     avail_we = (32'(req.res_index) < MAX_RES);
                  end
                  FUNC_WR_ALLOC: begin
                     alloc_we = (32'(req.proc_index) < MAX_PROCS) &&
                                (32'(req.res_index) < MAX_RES);
                  end
                  FUNC_WR_REQ: begin
                     reqm_we = (32'(req.proc_index) < MAX_PROCS) &&
                               (32'(req.res_index) < MAX_RES);
                  end
                  FUNC_CHECK, FUNC_WHAT_IF: begin
                     np_in       = np_clamped;
                     nr_in       = nr_clamped;
                     extra_in    = (req.func == FUNC_WHAT_IF);
                     xp_in       = req.proc_index;
                     xr_in       = req.res_index;
                     p_in        = '0;
                     r_in        = '0;
                     holds_in    = 1'b0;
                     progress_in = 1'b0;
                     done_in     = '0;
                     marks_in    = '0;
                     if (np_clamped == '0) begin
                        state_in = ST_DONE;
                     end else if (nr_clamped == '0) begin
                        // no resource types: nobody holds anything
                        for (int i = 0; i < MAX_PROCS; i++) begin
                           marks_in[i] = (i < 32'(np_clamped));
                        end
                        done_in  = np_clamped;
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_INIT_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_INIT_RD: state_in = ST_INIT_WR;

         ST_INIT_WR: begin
            work_we    = 1'b1;
            work_wdata = WORK_W'(avail_q);
            if (r_last) begin
               r_in     = '0;
               p_in     = '0;
               state_in = ST_HOLD_RD;
            end else begin
               r_in     = r_ff + 1'b1;
               state_in = ST_INIT_RD;
            end
         end

         ST_HOLD_RD: state_in = ST_HOLD_OP;

         ST_HOLD_OP: begin
            if (r_last) begin
               if (!any_held) begin
                  marks_in[p_ff[PIDX_W-1:0]] = 1'b1;
                  done_in = done_ff + 1'b1;
               end
               holds_in = 1'b0;
               r_in     = '0;
               if (p_last) begin
                  p_in        = '0;
                  progress_in = 1'b0;
                  state_in    = ST_PICK;
               end else begin
                  p_in     = p_ff + 1'b1;
                  state_in = ST_HOLD_RD;
               end
            end else begin
               holds_in = any_held;
               r_in     = r_ff + 1'b1;
               state_in = ST_HOLD_RD;
            end
         end

         ST_PICK: begin
            if (p_ff == np_ff) begin
               if (progress_ff) begin
                  p_in        = '0;
                  progress_in = 1'b0;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (marks_ff[p_ff[PIDX_W-1:0]]) begin
               p_in = p_ff + 1'b1;
            end else begin
               r_in     = '0;
               fits_in  = 1'b1;
               state_in = ST_FIT_RD;
            end
         end

         ST_FIT_RD: state_in = ST_FIT_OP;

         ST_FIT_OP: begin
            if (r_last) begin
               r_in = '0;
               if (fits_ff && fit_now) begin
                  state_in = ST_ADD_RD;
               end else begin
                  p_in     = p_ff + 1'b1;
                  state_in = ST_PICK;
               end
            end else begin
               fits_in  = fits_ff && fit_now;
               r_in     = r_ff + 1'b1;
               state_in = ST_FIT_RD;
            end
         end

         ST_ADD_RD: state_in = ST_ADD_OP;

         ST_ADD_OP: begin
            work_we = 1'b1;
            if (r_last) begin
               marks_in[p_ff[PIDX_W-1:0]] = 1'b1;
               done_in     = done_ff + 1'b1;
               progress_in = 1'b1;
               p_in        = p_ff + 1'b1;
               r_in        = '0;
               state_in    = ST_PICK;
            end else begin
               r_in     = r_ff + 1'b1;
               state_in = ST_ADD_RD;
            end
         end

         ST_DONE: begin
            // wait for the output slot
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.deadlocked     = (done_ff != np_ff);
               rsp_in.finished_count = 5'(done_ff);
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         p_ff         <= '0;
         r_ff         <= '0;
         np_ff        <= '0;
         nr_ff        <= '0;
         done_ff      <= '0;
         marks_ff     <= '0;
         holds_ff     <= 1'b0;
         fits_ff      <= 1'b0;
         progress_ff  <= 1'b0;
         extra_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p_ff         <= p_in;
         r_ff         <= r_in;
         np_ff        <= np_in;
         nr_ff        <= nr_in;
         done_ff      <= done_in;
         marks_ff     <= marks_in;
         holds_ff     <= holds_in;
         fits_ff      <= fits_in;
         progress_ff  <= progress_in;
         extra_ff     <= extra_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      xp_ff  <= xp_in;
      xr_ff  <= xr_in;
      rsp_ff <= rsp_in;
   end

   // finished count tracks the finish marks exactly
   a_done_matches_marks: assert property (@(posedge clock) disable iff (reset)
      done_ff == PCNT_W'($countones(marks_ff)))
      else $error("finished count out of step with finish marks");

   // no process outside the active range is ever marked
   a_marks_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> ((marks_ff >> np_ff) == '0))
      else $error("finish mark set beyond active processes");

   a_done_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (done_ff <= np_ff))
      else $error("more finished processes than active ones");

   // a pass without progress ends the check
   a_pass_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PICK && p_ff == np_ff && !progress_ff) |=> (state_ff == ST_DONE))
      else $error("check did not terminate after a pass without progress");

endmodule

[src/ddet_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ddet_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

[bench/ddet_outcome_checker.sv]
`timescale 1ns / 100ps
// Outcome checker for the deadlock detection engine: tracks the stores and CSRs,
// predicts each check result and compares it with the rsp channel. Depends on ddet_pkg.
module ddet_outcome_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  ddet_pkg::ddet_req_type         req,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  ddet_pkg::ddet_rsp_type         rsp,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [ddet_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ddet_pkg::CFG_W-1:0]     csr_data,
   output int                             results_due,
   output int                             fail_count
);

   import ddet_pkg::*;

   logic [COUNT_WIDTH-1:0] avail_q [MAX_RES] = '{default: '0};
   logic [COUNT_WIDTH-1:0] alloc_q [MAX_PROCS][MAX_RES] = '{default: '{default: '0}};
   logic [COUNT_WIDTH-1:0] claim_q [MAX_PROCS][MAX_RES] = '{default: '{default: '0}};
   logic [CFG_W-1:0]       procs_cfg = CFG_W'(1);
   logic [CFG_W-1:0]       res_cfg   = CFG_W'(1);
   ddet_rsp_type           outcome_q [$];
   ddet_rsp_type           due;

   // graph reduction: finish every process whose claims fit, return its holdings
   function automatic ddet_rsp_type reduce_graph(input bit extra, input logic [3:0] xp,
                                                 input logic [3:0] xr);
      logic [WORK_W-1:0] work [MAX_RES];
      bit                done_mark [MAX_PROCS];
      ddet_rsp_type      outcome;
      int                np;
      int                nr;
      int                done_cnt;
      bit                progress;
      bit                fits;
      bit                holds;
      logic [NEED_W-1:0] need;
      np = (int'(procs_cfg) > MAX_PROCS) ? MAX_PROCS : int'(procs_cfg);
      nr = (int'(res_cfg) > MAX_RES) ? MAX_RES : int'(res_cfg);
      for (int r = 0; r < MAX_RES; r++)
         work[r] = (r < nr) ? WORK_W'(avail_q[r]) : '0;
      for (int p = 0; p < MAX_PROCS; p++) begin
         holds = 1'b0;
         if (p < np)
            for (int r = 0; r < nr; r++)
               if (alloc_q[p][r] != '0) holds = 1'b1;
         done_mark[p] = (p < np) && !holds;
      end
      do begin
         progress = 1'b0;
         for (int p = 0; p < np; p++) begin
            if (!done_mark[p]) begin
               fits = 1'b1;
               for (int r = 0; r < nr; r++) begin
                  need = NEED_W'(claim_q[p][r]);
                  if (extra && p == int'(xp) && r == int'(xr)) need = need + 1'b1;
                  if (WORK_W'(need) > work[r]) fits = 1'b0;
               end
               if (fits) begin
                  for (int r = 0; r < nr; r++)
                     work[r] = work[r] + WORK_W'(alloc_q[p][r]);
                  done_mark[p] = 1'b1;
                  progress = 1'b1;
               end
            end
         end
      end while (progress);
      done_cnt = 0;
      for (int p = 0; p < np; p++)
         if (done_mark[p]) done_cnt++;
      outcome.deadlocked     = (done_cnt != np);
      outcome.finished_count = 5'(done_cnt);
      return outcome;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         outcome_q.delete();
         procs_cfg = CFG_W'(1);
         res_cfg   = CFG_W'(1);
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               $error("unexpected rsp transaction: deadlocked %0d finished_count %0d",
                      rsp.deadlocked, rsp.finished_count);
               fail_count++;
            end else begin
               due = outcome_q.pop_front();
               if (rsp.deadlocked !== due.deadlocked) begin
                  $error("deadlocked: expected %0d actual %0d", due.deadlocked, rsp.deadlocked);
                  fail_count++;
               end
               if (rsp.finished_count !== due.finished_count) begin
                  $error("finished_count: expected %0d actual %0d",
                         due.finished_count, rsp.finished_count);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            case (req.func)
               FUNC_WR_AVAIL: avail_q[req.res_index] = req.value;
               FUNC_WR_ALLOC: alloc_q[req.proc_index][req.res_index] = req.value;
               FUNC_WR_REQ:   claim_q[req.proc_index][req.res_index] = req.value;
               FUNC_CHECK:    outcome_q.push_back(reduce_graph(1'b0, '0, '0));
               FUNC_WHAT_IF:
                  outcome_q.push_back(reduce_graph(1'b1, req.proc_index, req.res_index));
               default: ;
            endcase
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NUM_PROCS: procs_cfg = csr_data;
               CSR_NUM_RES:   res_cfg   = csr_data;
               default: ;
            endcase
         end
      end
      results_due <= outcome_q.size();
   end

endmodule

[bench/deadlock_detection_engine_core_test.sv]
`timescale 1ns / 100ps
// Top of the deadlock detection engine bench: clock, reset, req/csr stimulus, rsp back-pressure
// and the verdict. Depends on ddet_pkg, deadlock_detection_engine_core and ddet_outcome_checker.
module deadlock_detection_engine_core_test;
   import ddet_pkg::*;

   localparam int ITEM_GOAL     = 1050;  // counted transactions before the run winds down
   localparam int CALM_TAIL     = 120;   // last stretch runs with no idling on either side
   localparam int LONG_HOLD     = 400;   // cycles of rsp back-pressure, asked for once in phase 4
   localparam int SETTLE_CYCLES = 16;    // a write can still be in flight after the last rsp
   localparam int FUNC_TOP      = 7;     // largest code the func field can carry

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   ddet_req_type         req       = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   ddet_rsp_type         rsp;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data  = '0;
   int                   results_due;
   int                   fail_count;

   // bench-side view of what the block holds, so checks only ever read written entries
   bit                   avail_known [MAX_RES];
   bit                   alloc_known [MAX_PROCS][MAX_RES];
   bit                   claim_known [MAX_PROCS][MAX_RES];
   logic [CFG_W-1:0]     procs_set = CFG_W'(1);
   logic [CFG_W-1:0]     res_set   = CFG_W'(1);

   int                   items_sent        = 0;
   bit                   calm              = 1'b0;  // no idling at all once set
   int                   gap_odds          = 5;     // 1-in-N chance of a sender gap, 0 = none
   bit                   long_hold_pending = 1'b0;  // asks the rsp side for one long stall
   int                   rsp_hold_left     = 0;
   int                   rsp_mood_left     = 0;
   bit                   rsp_choppy        = 1'b1;

   deadlock_detection_engine_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   ddet_outcome_checker outcome_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp         (rsp),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .results_due (results_due),
      .fail_count  (fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop; generous against the slowest legal run (full-size checks, worst stalls).
   initial begin
      #50_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // rsp back-pressure: alternates choppy and clean moods, plus one long hold on request
   // so that a result parks in the rsp slot, the next check stalls and req_ready drops.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else if (long_hold_pending) begin
         long_hold_pending = 1'b0;
         rsp_hold_left = LONG_HOLD - 1;
         rsp_ready <= 1'b0;
      end else if (!calm && rsp_choppy && $urandom_range(0, 4) == 0) begin
         rsp_hold_left = $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
      if (rsp_mood_left == 0) begin
         rsp_choppy = ($urandom_range(0, 2) != 0);
         rsp_mood_left = $urandom_range(50, 300);
      end else begin
         rsp_mood_left--;
      end
   end

   function automatic ddet_req_type make_item(input logic [2:0] fn, input int p, input int r,
                                              input logic [15:0] v);
      ddet_req_type item;
      item.func       = fn;
      item.proc_index = 4'(p);
      item.res_index  = 4'(r);
      item.value      = v;
      return item;
   endfunction

   // CSR values above the array size act as the full size
   function automatic int span(input logic [CFG_W-1:0] v, input int cap);
      return (int'(v) > cap) ? cap : int'(v);
   endfunction

   // mostly small counts so that outcomes mix; extremes and full-width values now and then
   function automatic logic [15:0] pick_count();
      case ($urandom_range(0, 19))
         0:       return '1;
         1:       return 16'($urandom);
         2, 3, 4: return '0;
         default: return 16'($urandom_range(1, 4));
      endcase
   endfunction

   // Offer one transaction; valid holds with a stable payload until accepted.
   task automatic send_item(input ddet_req_type item);
      int gap;
      gap = 0;
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
         gap = $urandom_range(1, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      case (item.func)
         FUNC_WR_AVAIL: avail_known[item.res_index] = 1'b1;
         FUNC_WR_ALLOC: alloc_known[item.proc_index][item.res_index] = 1'b1;
         FUNC_WR_REQ:   claim_known[item.proc_index][item.res_index] = 1'b1;
         default: ;
      endcase
      if (item.func <= FUNC_WHAT_IF) items_sent++;
   endtask

   // Stop offering, wait for every predicted result, then let a trailing write settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One CSR transaction; the caller lowers csr_valid after the last of a batch.
   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic apply_config(input logic [CFG_W-1:0] np, input logic [CFG_W-1:0] nr);
      csr_put(CSR_NUM_PROCS, np);
      csr_put(CSR_NUM_RES, nr);
      csr_valid <= 1'b0;
      procs_set = np;
      res_set   = nr;
   endtask

   // Write every entry a check can touch under the current sizes that was never written.
   task automatic fill_region();
      int np;
      int nr;
      np = span(procs_set, MAX_PROCS);
      nr = span(res_set, MAX_RES);
      for (int r = 0; r < nr; r++)
         if (!avail_known[r]) send_item(make_item(FUNC_WR_AVAIL, 0, r, pick_count()));
      for (int p = 0; p < np; p++)
         for (int r = 0; r < nr; r++) begin
            if (!alloc_known[p][r]) send_item(make_item(FUNC_WR_ALLOC, p, r, pick_count()));
            if (!claim_known[p][r]) send_item(make_item(FUNC_WR_REQ, p, r, pick_count()));
         end
   endtask

   // A few entry updates, mostly inside the active rows and columns, then a check or what-if.
   task automatic run_scenario();
      int         np;
      int         nr;
      int         p;
      int         r;
      logic [2:0] fn;
      np = span(procs_set, MAX_PROCS);
      nr = span(res_set, MAX_RES);
      repeat ($urandom_range(1, 6)) begin
         if (np == 0 || nr == 0 || $urandom_range(0, 9) == 0) begin
            p = $urandom_range(0, MAX_PROCS - 1);
            r = $urandom_range(0, MAX_RES - 1);
         end else begin
            p = $urandom_range(0, np - 1);
            r = $urandom_range(0, nr - 1);
         end
         case ($urandom_range(0, 2))
            0:       fn = FUNC_WR_AVAIL;
            1:       fn = FUNC_WR_ALLOC;
            default: fn = FUNC_WR_REQ;
         endcase
         send_item(make_item(fn, p, r, pick_count()));
      end
      // stray codes the block must swallow without a response
      if ($urandom_range(0, 11) == 0)
         send_item(make_item(3'($urandom_range(int'(FUNC_WHAT_IF) + 1, FUNC_TOP)),
                             $urandom, $urandom, 16'($urandom)));
      if (np != 0 && nr != 0 && $urandom_range(0, 5) != 0) begin
         p = $urandom_range(0, np - 1);
         r = $urandom_range(0, nr - 1);
      end else begin
         p = $urandom_range(0, MAX_PROCS - 1);
         r = $urandom_range(0, MAX_RES - 1);
      end
      fn = ($urandom_range(0, 1) == 0) ? FUNC_CHECK : FUNC_WHAT_IF;
      // an unused what-if target is only named when that request entry holds data
      if ((p >= np || r >= nr) && !claim_known[p][r]) fn = FUNC_CHECK;
      send_item(make_item(fn, p, r, 16'($urandom)));
   endtask

   initial begin : stimulus
      int               phase;
      int               n_scen;
      logic [CFG_W-1:0] want_p;
      logic [CFG_W-1:0] want_r;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset sizes (one process, one resource).
      send_item(make_item(FUNC_WR_AVAIL, 0, 0, '1));
      send_item(make_item(FUNC_WR_ALLOC, 0, 0, '0));
      send_item(make_item(FUNC_WR_REQ, 0, 0, '1));
      send_item(make_item(FUNC_CHECK, 0, 0, '1));      // holds nothing: finished up front
      send_item(make_item(FUNC_WR_ALLOC, 0, 0, '1));
      send_item(make_item(FUNC_CHECK, 0, 0, '0));      // full-count claim just fits
      send_item(make_item(FUNC_WHAT_IF, 0, 0, '1));    // one over full count, must not wrap
      // entries beyond the active sizes are stored but ignored
      send_item(make_item(FUNC_WR_REQ, 15, 15, 16'h5A5A));
      send_item(make_item(FUNC_WR_ALLOC, 15, 15, '1));
      send_item(make_item(FUNC_WR_AVAIL, 0, 15, '0));
      send_item(make_item(FUNC_WHAT_IF, 15, 15, '0)); // unused target: same as a plain check
      for (int f = int'(FUNC_WHAT_IF) + 1; f <= FUNC_TOP; f++)
         send_item(make_item(3'(f), $urandom, $urandom, 16'($urandom)));
      send_item(make_item(FUNC_WR_AVAIL, 0, 0, '0));
      send_item(make_item(FUNC_CHECK, 0, 0, '0));      // claim cannot be met: deadlock
      send_item(make_item(FUNC_WR_REQ, 0, 0, '0));
      send_item(make_item(FUNC_CHECK, 0, 0, '0));
      send_item(make_item(FUNC_WHAT_IF, 0, 0, '0));    // zero available, one asked
      drain();
      // no processes in use, plus a write to an index with no register behind it
      csr_put(CSR_NUM_PROCS, '0);
      csr_put(CSR_IDX_W'(int'(CSR_NUM_RES) + 1), '1);
      csr_valid <= 1'b0;
      procs_set = '0;
      send_item(make_item(FUNC_CHECK, 0, 0, '0));
      send_item(make_item(FUNC_WHAT_IF, 0, 0, '0));
      drain();
      // no resources in use: every process holds nothing
      apply_config(CFG_W'(1), '0);
      send_item(make_item(FUNC_CHECK, 0, 0, '0));
      send_item(make_item(FUNC_WHAT_IF, 0, 0, '0));

      // Random part: each phase picks sizes, fills new entries, then runs scenarios.
      // Full-size phases come first and are short; the rest stay small to keep checks quick.
      phase = 0;
      while (items_sent < ITEM_GOAL) begin
         case (phase)
            0: begin
               want_p = CFG_W'(MAX_PROCS);
               want_r = CFG_W'(MAX_RES);
            end
            1: begin
               want_p = '1;
               want_r = '1;
            end
            2: begin
               want_p = '0;
               want_r = CFG_W'($urandom_range(1, MAX_RES));
            end
            3: begin
               want_p = CFG_W'($urandom_range(1, 8));
               want_r = '0;
            end
            default: begin
               if ($urandom_range(0, 7) == 0) begin
                  want_p = CFG_W'($urandom_range(7, MAX_PROCS));
                  want_r = CFG_W'($urandom_range(1, 3));
               end else begin
                  want_p = CFG_W'($urandom_range(1, 6));
                  want_r = CFG_W'($urandom_range(1, 5));
               end
            end
         endcase
         drain();
         apply_config(want_p, want_r);
         fill_region();
         calm = calm || (items_sent >= ITEM_GOAL - CALM_TAIL);
         gap_odds = ($urandom_range(0, 2) == 0) ? 0 : 5;
         if (phase == 4) long_hold_pending = 1'b1;
         n_scen = (phase < 2) ? 4 : $urandom_range(6, 16);
         for (int k = 0; k < n_scen; k++) begin
            run_scenario();
            // sender pause: let the engine empty out completely mid-phase
            if (phase == 6 && k == n_scen / 2) drain();
         end
         phase++;
      end

      drain();
      if (fail_count == 0 && results_due == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
